FILE: rtl/ssidm_pkg.sv
// Shared types and constants for the sorted store with remove-largest.
package ssidm_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int HCNT_W   = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic [HCNT_W-1:0]        held_count;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] smallest_value;
    logic signed [DATA_W-1:0] largest_value;
  } out_t;

  // broadcast from the top to every cell
  typedef struct packed {
    logic                     ins_en;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } cell_ctl_t;

  // handed from a cell to its right-hand neighbor
  typedef struct packed {
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

endpackage

FILE: rtl/ssidm_cell.sv
// One storage cell of the sorted chain: compare, shift-right and place.
module ssidm_cell
  import ssidm_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  cell_link_t       left,
  output cell_link_t       link,
  output logic             sel_top,
  output logic             sel_sec
);

  logic signed [DATA_W-1:0] value_r;
  logic                     occ;
  logic                     is_free_head;
  logic [CNT_W:0]           idx_w;
  logic [CNT_W:0]           cnt_w;

  assign idx_w        = (CNT_W+1)'(idx);
  assign cnt_w        = (CNT_W+1)'(ctl.count);
  assign occ          = idx_w < cnt_w;
  assign is_free_head = idx_w == cnt_w;
  assign sel_top      = (idx_w + (CNT_W+1)'(1)) == cnt_w;
  assign sel_sec      = (idx_w + (CNT_W+1)'(2)) == cnt_w;

  assign link.gt    = occ && (value_r > ctl.value);
  assign link.value = value_r;

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (left.gt) begin
        value_r <= left.value;
      end else if (link.gt || is_free_head) begin
        value_r <= ctl.value;
      end
    end
  end

endmodule

FILE: rtl/sorted_store_insert_delete_max_top.sv
// Sorted store of signed 32-bit values with insert and remove-largest.
// Holds up to CAPACITY values in ascending order in a row of cells; an insert
// compares in every cell at once and shifts the larger values one cell up in
// the same cycle, a remove only lowers the count. The result of each command is
// registered: it shows on out_item the cycle after acceptance, so one item per
// cycle is sustained while out_stall is low. While a result is held by
// out_stall, in_stall is high; the next item is taken in the cycle that result
// leaves. Equal values keep arrival order. An insert into a full store is
// dropped with status 3, a remove from an empty store returns 2.
module sorted_store_insert_delete_max_top
  import ssidm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  out_t                     out_r, out_nxt;
  cell_ctl_t                ctl;
  cell_link_t               link [CAPACITY];
  logic [CAPACITY-1:0]      sel_top, sel_sec, gt_vec;
  logic signed [DATA_W-1:0] top_v, sec_v, low_v;
  logic                     accept, empty, full, any_gt;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign empty = count_r == '0;
  assign full  = count_r == CNT_W'(CAPACITY);

  assign ctl.ins_en = accept && (in_item.command == CMD_INSERT) && !full;
  assign ctl.value  = in_item.value;
  assign ctl.count  = count_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = link[i-1];
    end
    ssidm_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .ctl     (ctl),
      .left    (left),
      .link    (link[i]),
      .sel_top (sel_top[i]),
      .sel_sec (sel_sec[i])
    );
    assign gt_vec[i] = link[i].gt;
  end

  assign low_v  = link[0].value;
  assign any_gt = |gt_vec;

  always_comb begin
    top_v = '0;
    sec_v = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      top_v = top_v | (link[i].value & {DATA_W{sel_top[i]}});
      sec_v = sec_v | (link[i].value & {DATA_W{sel_sec[i]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    out_nxt   = '0;
    if (in_item.command == CMD_INSERT) begin
      if (full) begin
        out_nxt.status         = ST_FULL;
        out_nxt.smallest_value = low_v;
        out_nxt.largest_value  = top_v;
      end else begin
        count_nxt              = count_r + CNT_W'(1);
        out_nxt.status         = ST_INSERTED;
        out_nxt.smallest_value = (empty || gt_vec[0]) ? in_item.value : low_v;
        out_nxt.largest_value  = any_gt ? top_v : in_item.value;
      end
    end else begin
      if (empty) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        count_nxt             = count_r - CNT_W'(1);
        out_nxt.status        = ST_REMOVED;
        out_nxt.removed_value = top_v;
        if (count_r != CNT_W'(1)) begin
          out_nxt.smallest_value = low_v;
          out_nxt.largest_value  = sec_v;
        end
      end
    end
    out_nxt.held_count = HCNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/ssidm_checker.sv
// Port-level checks for the sorted store, bound to the top level.
module ssidm_checker
  import ssidm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_item,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid &&
      (($past(in_item.command) == CMD_REMOVE) ==
       (out_item.status == ST_REMOVED || out_item.status == ST_EMPTY)))
    else $error("accepted item gave no matching result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.held_count == '0 |->
      out_item.smallest_value == '0 && out_item.largest_value == '0)
    else $error("empty store reports nonzero extremes");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_REMOVED |-> out_item.removed_value == '0)
    else $error("removed value set without a remove");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.held_count != '0 |->
      out_item.smallest_value <= out_item.largest_value)
    else $error("smallest above largest");

endmodule

bind sorted_store_insert_delete_max_top ssidm_checker u_ssidm_checker (.*);

FILE: verif/tb_sorted_store_insert_delete_max_top.sv
// Testbench for the sorted store: directed and random insert/remove items checked against a predictor.
`timescale 1ns / 100ps

module tb_sorted_store_insert_delete_max_top;
  import ssidm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;

  class store_scoreboard;
    logic signed [DATA_W-1:0] held[CAPACITY];
    int count;
    int errors;
    out_t expected_q[$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void note_command(in_t it);
      out_t r;
      int pos;
      logic signed [DATA_W-1:0] v;
      r = '0;
      v = it.value;
      if (it.command == CMD_INSERT) begin
        if (count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < count && held[pos] <= v) pos++;
          for (int i = count; i > pos; i--) held[i] = held[i - 1];
          held[pos] = v;
          count++;
          r.status = ST_INSERTED;
        end
      end else begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          count--;
          r.removed_value = held[count];
          r.status = ST_REMOVED;
        end
      end
      r.held_count = count[HCNT_W-1:0];
      if (count != 0) begin
        r.smallest_value = held[0];
        r.largest_value = held[count - 1];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.held_count !== exp.held_count)
        report($sformatf("held_count got %0d exp %0d", got.held_count, exp.held_count));
      if (got.removed_value !== exp.removed_value)
        report($sformatf("removed_value got %0d exp %0d",
                         got.removed_value, exp.removed_value));
      if (got.smallest_value !== exp.smallest_value)
        report($sformatf("smallest_value got %0d exp %0d",
                         got.smallest_value, exp.smallest_value));
      if (got.largest_value !== exp.largest_value)
        report($sformatf("largest_value got %0d exp %0d",
                         got.largest_value, exp.largest_value));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  store_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  sorted_store_insert_delete_max_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check accepted items, then pick next stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 16);
      end
    end
  end

  function automatic in_t make_cmd(logic cmd, logic signed [DATA_W-1:0] val);
    in_t it;
    it.command = cmd;
    it.value = val;
    return it;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(16)) - 8;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input in_t it);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(it);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_left;
    int ins_pct;
    in_t it;
    phase_left = 0;
    ins_pct = 50;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // remove on empty, extremes, duplicates, fill to full, insert when full
    send_item(make_cmd(CMD_REMOVE, 32'sh1234_5678));
    send_item(make_cmd(CMD_INSERT, 32'sh7FFF_FFFF));
    send_item(make_cmd(CMD_INSERT, 32'sh8000_0000));
    send_item(make_cmd(CMD_INSERT, 0));
    send_item(make_cmd(CMD_INSERT, -1));
    send_item(make_cmd(CMD_INSERT, 0));
    send_item(make_cmd(CMD_INSERT, 32'sh7FFF_FFFF));
    send_item(make_cmd(CMD_REMOVE, 0));
    send_item(make_cmd(CMD_REMOVE, -1));
    for (int i = 0; i < 12; i++)
      send_item(make_cmd(CMD_INSERT, (i % 2 ? 32'sh5555_5555 : 32'shAAAA_AAAA) + i));
    send_item(make_cmd(CMD_INSERT, 32'sh8000_0000));
    send_item(make_cmd(CMD_REMOVE, 32'shFFFF_FFFF));
    send_item(make_cmd(CMD_REMOVE, 0));

    for (int n = 0; n < 700; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0: ins_pct = 80;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
      end
      phase_left--;
      if (n == 120 || n == 600) hold_req = 1'b1;
      if (n == 250) quiet = 1'b1;
      if (n == 360) quiet = 1'b0;
      if (n == 450) wait_for_results();
      it.command = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
      it.value = rand_value();
      send_item(it);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
